FILE: hdl/kbd_backlight_hotkey_ctrl_assert.svh
// Assertion macros for the keyboard backlight hotkey controller.
// Expects a clock named clock and a synchronous active-high reset named reset.
`ifndef KBD_BACKLIGHT_HOTKEY_CTRL_ASSERT_SVH
`define KBD_BACKLIGHT_HOTKEY_CTRL_ASSERT_SVH

// Checked on every rising edge outside reset.
`define KBL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define KBL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/kbl_pkg.sv
// Shared types, codes and constant tables of the keyboard backlight controller.
// No dependencies; used by the channel interfaces and the top level.
package kbl_pkg;

   localparam int OPCODE_W   = 3;
   localparam int LEVEL_W    = 8;
   localparam int COLOR_IN_W = 32;
   localparam int COLOR_W    = 24;
   localparam int STATUS_W   = 2;

   // Both tables have room for sixteen entries; the configured counts pick a prefix.
   localparam int TABLE_SLOTS = 16;
   localparam int TABLE_IDX_W = 4;

   localparam logic [LEVEL_W-1:0] DEFAULT_SAVED = 8'd72;
   localparam logic [COLOR_W-1:0] COLOR_WHITE   = 24'hFFFFFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET_LEVEL = 3'd0,
      OP_FW_REPORT = 3'd1,
      OP_TOGGLE    = 3'd2,
      OP_DOWN      = 3'd3,
      OP_UP        = 3'd4,
      OP_COLOR_CYC = 3'd5,
      OP_SET_COLOR = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_COLOR = 2'd1,
      STATUS_IGNORED   = 2'd2
   } status_type;

   typedef logic [LEVEL_W-1:0] level_table_type [TABLE_SLOTS];
   typedef logic [COLOR_W-1:0] color_table_type [TABLE_SLOTS];

   localparam level_table_type LEVEL_TABLE = '{
      8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255
   };

   localparam color_table_type COLOR_TABLE = '{
      24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFF00FF,
      24'h00FF00, 24'h00FFFF, 24'hFFFF00, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000
   };

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [LEVEL_W-1:0]    level_in;
      logic                  report_ok;
      logic [COLOR_IN_W-1:0] color_in;
   } req_type;

   typedef struct packed {
      logic               level_write;
      logic [LEVEL_W-1:0] level_out;
      logic               color_write;
      logic [COLOR_W-1:0] color_out;
      logic               changed_notify;
      status_type         status;
   } rsp_type;

endpackage

FILE: hdl/kbl_req_if.sv
// Event channel of the keyboard backlight controller: valid, ready and one event.
// Depends on kbl_pkg for the field widths.
interface kbl_req_if;
   logic                           valid;
   logic                           ready;
   logic [kbl_pkg::OPCODE_W-1:0]   opcode;
   logic [kbl_pkg::LEVEL_W-1:0]    level_in;
   logic                           report_ok;
   logic [kbl_pkg::COLOR_IN_W-1:0] color_in;

   modport source (output valid, opcode, level_in, report_ok, color_in, input ready);
   modport sink   (input valid, opcode, level_in, report_ok, color_in, output ready);
endinterface

FILE: hdl/kbl_rsp_if.sv
// Result channel of the keyboard backlight controller: valid, ready and one result.
// Depends on kbl_pkg for the field widths.
interface kbl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         level_write;
   logic [kbl_pkg::LEVEL_W-1:0]  level_out;
   logic                         color_write;
   logic [kbl_pkg::COLOR_W-1:0]  color_out;
   logic                         changed_notify;
   logic [kbl_pkg::STATUS_W-1:0] status;

   modport source (output valid, level_write, level_out, color_write, color_out,
                   changed_notify, status, input ready);
   modport sink   (input valid, level_write, level_out, color_write, color_out,
                   changed_notify, status, output ready);
endinterface

FILE: hdl/kbd_backlight_hotkey_ctrl.sv
// Keyboard backlight hotkey controller: level, saved level and colour state.
// Depends on kbl_pkg, kbl_req_if, kbl_rsp_if and kbd_backlight_hotkey_ctrl_assert.svh.
//
// Usage:
//   Events arrive on req_if (valid/ready); each accepted beat gives exactly one
//   result beat on rsp_if. csr_wr_en/csr_wr_data write the colour-capable flag,
//   which also re-initialises the saved level; write it only while idle.
//   An event is captured in an input register, settled against the level and
//   colour tables as it passes to the result register and offered from there.
//   Throughput is one event per cycle while the receiver takes each result beat:
//   the input register and the result register form a two-deep pipeline, and
//   the input register refills in the same cycle as it passes its event on.
//   When the receiver stalls, the result register holds its beat, the input
//   register holds the next one and req_if.ready drops once both are full.
//   Synchronous reset empties both registers, sets the level to dark, the
//   saved level to 72, the colour to white and enables colour support.
//   NUM_LEVELS and NUM_COLORS (2 to 16) select how many table entries are used.
module kbd_backlight_hotkey_ctrl #(
   parameter int NUM_LEVELS = 6,
   parameter int NUM_COLORS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   kbl_req_if.sink    req_if,
   kbl_rsp_if.source  rsp_if
);

   logic                               req_valid_ff;
   kbl_pkg::req_type                   req_ff;
   logic                               rsp_valid_ff;
   kbl_pkg::rsp_type                   rsp_ff;
   kbl_pkg::rsp_type                   rsp_in;
   logic                               capable_ff;
   logic [kbl_pkg::LEVEL_W-1:0]        level_ff;
   logic [kbl_pkg::LEVEL_W-1:0]        level_in;
   logic [kbl_pkg::LEVEL_W-1:0]        saved_ff;
   logic [kbl_pkg::LEVEL_W-1:0]        saved_in;
   logic [kbl_pkg::COLOR_W-1:0]        color_ff;
   logic [kbl_pkg::COLOR_W-1:0]        color_in;
   logic                               advance;
   logic                               lit;
   logic                               down_hit;
   logic [kbl_pkg::LEVEL_W-1:0]        down_level;
   logic                               up_hit;
   logic [kbl_pkg::LEVEL_W-1:0]        up_level;
   logic [kbl_pkg::TABLE_IDX_W-1:0]    color_next_idx;
   logic [kbl_pkg::COLOR_W-1:0]        color_next;

   // The input register passes its beat on whenever the result register is free or its beat is being taken.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;
   assign lit          = (level_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         req_ff.opcode    <= req_if.opcode;
         req_ff.level_in  <= req_if.level_in;
         req_ff.report_ok <= req_if.report_ok;
         req_ff.color_in  <= req_if.color_in;
      end
   end

   // Next lower entry: the highest table index below the level wins.
   always_comb begin
      down_hit   = 1'b0;
      down_level = level_ff;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (kbl_pkg::LEVEL_TABLE[kbl_pkg::TABLE_IDX_W'(i)] < level_ff) begin
            down_hit   = 1'b1;
            down_level = kbl_pkg::LEVEL_TABLE[kbl_pkg::TABLE_IDX_W'(i)];
         end
      end
   end

   // Next higher entry: the lowest table index above the level wins.
   always_comb begin
      up_hit   = 1'b0;
      up_level = level_ff;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (kbl_pkg::LEVEL_TABLE[kbl_pkg::TABLE_IDX_W'(i)] > level_ff) begin
            up_hit   = 1'b1;
            up_level = kbl_pkg::LEVEL_TABLE[kbl_pkg::TABLE_IDX_W'(i)];
         end
      end
   end

   // The first matching colour decides; no match, or a match on the last
   // entry, wraps to the first entry.
   always_comb begin
      color_next_idx = '0;
      for (int i = NUM_COLORS - 1; i >= 0; i--) begin
         if (kbl_pkg::COLOR_TABLE[kbl_pkg::TABLE_IDX_W'(i)] == color_ff) begin
            if (i < NUM_COLORS - 1) begin
               color_next_idx = kbl_pkg::TABLE_IDX_W'(i + 1);
            end else begin
               color_next_idx = '0;
            end
         end
      end
      color_next = kbl_pkg::COLOR_TABLE[color_next_idx];
   end

   always_comb begin
      level_in = level_ff;
      saved_in = saved_ff;
      color_in = color_ff;
      rsp_in.level_write    = 1'b0;
      rsp_in.color_write    = 1'b0;
      rsp_in.changed_notify = 1'b0;
      rsp_in.status         = kbl_pkg::STATUS_OK;
      unique case (kbl_pkg::opcode_type'(req_ff.opcode))
         kbl_pkg::OP_SET_LEVEL: begin
            level_in           = req_ff.level_in;
            rsp_in.level_write = 1'b1;
         end
         kbl_pkg::OP_FW_REPORT: begin
            if (req_ff.report_ok) begin
               level_in              = req_ff.level_in;
               rsp_in.changed_notify = 1'b1;
            end else begin
               rsp_in.status = kbl_pkg::STATUS_IGNORED;
            end
         end
         kbl_pkg::OP_TOGGLE: begin
            if (lit) begin
               saved_in = level_ff;
               level_in = '0;
            end else begin
               level_in = saved_ff;
            end
            rsp_in.level_write    = 1'b1;
            rsp_in.changed_notify = 1'b1;
         end
         kbl_pkg::OP_DOWN: begin
            if (lit) begin
               level_in           = down_level;
               rsp_in.level_write = down_hit;
            end else begin
               level_in           = saved_ff;
               rsp_in.level_write = 1'b1;
            end
            rsp_in.changed_notify = 1'b1;
         end
         kbl_pkg::OP_UP: begin
            if (lit) begin
               level_in           = up_level;
               rsp_in.level_write = up_hit;
            end else begin
               level_in           = saved_ff;
               rsp_in.level_write = 1'b1;
            end
            rsp_in.changed_notify = 1'b1;
         end
         kbl_pkg::OP_COLOR_CYC: begin
            if (!capable_ff) begin
               rsp_in.status = kbl_pkg::STATUS_IGNORED;
            end else begin
               if (lit) begin
                  color_in           = color_next;
                  rsp_in.color_write = 1'b1;
               end else begin
                  level_in           = saved_ff;
                  rsp_in.level_write = 1'b1;
               end
               rsp_in.changed_notify = 1'b1;
            end
         end
         kbl_pkg::OP_SET_COLOR: begin
            if (!capable_ff) begin
               rsp_in.status = kbl_pkg::STATUS_IGNORED;
            end else if (req_ff.color_in[kbl_pkg::COLOR_IN_W-1:kbl_pkg::COLOR_W] != '0) begin
               rsp_in.status = kbl_pkg::STATUS_BAD_COLOR;
            end else begin
               color_in           = req_ff.color_in[kbl_pkg::COLOR_W-1:0];
               rsp_in.color_write = 1'b1;
            end
         end
         default: begin
            rsp_in.status = kbl_pkg::STATUS_IGNORED;
         end
      endcase
      rsp_in.level_out = level_in;
      rsp_in.color_out = color_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capable_ff <= 1'b1;
         level_ff   <= '0;
         saved_ff   <= kbl_pkg::DEFAULT_SAVED;
         color_ff   <= kbl_pkg::COLOR_WHITE;
      end else if (csr_wr_en) begin
         capable_ff <= csr_wr_data;
         saved_ff   <= csr_wr_data ? kbl_pkg::DEFAULT_SAVED : '0;
      end else if (advance) begin
         level_ff <= level_in;
         saved_ff <= saved_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.level_write    = rsp_ff.level_write;
   assign rsp_if.level_out      = rsp_ff.level_out;
   assign rsp_if.color_write    = rsp_ff.color_write;
   assign rsp_if.color_out      = rsp_ff.color_out;
   assign rsp_if.changed_notify = rsp_ff.changed_notify;
   assign rsp_if.status         = rsp_ff.status;

`include "kbd_backlight_hotkey_ctrl_assert.svh"

   `KBL_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_valid_ff && !req_valid_ff), "pipeline not empty after reset")
   `KBL_ASSERT(a_advance_fills, advance |=> rsp_valid_ff, "beat lost between input and result register")
   `KBL_ASSERT(a_color_needs_cap, (rsp_valid_ff && rsp_ff.color_write) |-> capable_ff, "colour written without colour support")
   `KBL_ASSERT(a_write_means_ok, (rsp_valid_ff && (rsp_ff.level_write || rsp_ff.color_write)) |-> (rsp_ff.status == kbl_pkg::STATUS_OK), "write issued with an error status")
   `KBL_ASSERT(a_csr_saved, (csr_wr_en && !csr_wr_data) |=> (saved_ff == '0), "saved level not cleared on colour support off")

endmodule
